/* rtl/core/rqpc_pkg.sv */
// ----------------------------------------------------------------------------
// Read quality profile counter package
// Request kinds, readout table codes, summary selectors and nucleotide coding.
// ----------------------------------------------------------------------------
package rqpc_pkg;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] TBL_NUC  = 2'd0;
  localparam logic [1:0] TBL_QUAL = 2'd1;
  localparam logic [1:0] TBL_TR   = 2'd2;
  localparam logic [1:0] TBL_SUM  = 2'd3;

  localparam logic [5:0] SUM_MINLEN = 6'd0;
  localparam logic [5:0] SUM_MAXLEN = 6'd1;
  localparam logic [5:0] SUM_MAXQ   = 6'd2;
  localparam logic [5:0] SUM_READS  = 6'd3;

  localparam logic [2:0] NT_A = 3'd0;
  localparam logic [2:0] NT_C = 3'd1;
  localparam logic [2:0] NT_G = 3'd2;
  localparam logic [2:0] NT_T = 3'd3;
  localparam logic [2:0] NT_N = 3'd4;

  localparam logic [7:0] LEN_NONE = 8'd255;

  typedef logic [2:0] nt_code_t;

  // Upper and lower case letters map to the same code; anything else is N.
  function automatic nt_code_t nt_code(input logic [7:0] c);
    nt_code_t r;
    case (c)
      8'h41, 8'h61: r = NT_A;
      8'h43, 8'h63: r = NT_C;
      8'h47, 8'h67: r = NT_G;
      8'h54, 8'h74: r = NT_T;
      default:      r = NT_N;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/read_quality_profile_counter_core.sv */
// ----------------------------------------------------------------------------
// Read quality profile counter core
// Per-position nucleotide, quality and quality-transition counters held in
// three on-chip memories, updated by read-modify-write, plus read summaries.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | one base to add or one readout request
//  m_axis   | out       | one counter or summary value per readout request
//
//  One request is taken per cycle while s_axis_tready is high; a readout result
//  passes through the registered memory read and then the output register.
//  After reset a clearing pass zeroes the counter memories, during which
//  s_axis_tready is low.
//  A readout whose result cannot enter a full, stalled output register holds
//  the input side until the result moves on.
module read_quality_profile_counter_core #(
  parameter int MAX_READ_LEN = 128,
  parameter int MAX_QUALITY  = 63,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // base_char[7:0], quality[15:8], read_position[22:16], index_a[28:23],
  // index_b[34:29], zero fill[39:35]
  input  logic [39:0] s_axis_tdata,
  // action[0], table_select[2:1]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // count_value[31:0]
  output logic [31:0] m_axis_tdata,
  // bad_index[0]
  output logic        m_axis_tuser
);

  localparam int PW  = $clog2(MAX_READ_LEN);
  localparam int QW  = $clog2(MAX_QUALITY + 1);
  localparam int NAW = PW + 3;
  localparam int QAW = PW + QW;
  localparam int TAW = PW + 2 * QW;
  localparam int CW  = COUNT_WIDTH;

  logic [CW-1:0] nuc_mem  [0:(1 << NAW) - 1];
  logic [CW-1:0] qual_mem [0:(1 << QAW) - 1];
  logic [CW-1:0] tr_mem   [0:(1 << TAW) - 1];

  // Scalar state.
  logic [7:0]    base_position;
  logic [QW-1:0] previous_quality;
  logic [7:0]    min_len;
  logic [7:0]    max_len;
  logic [QW-1:0] max_quality;
  logic [31:0]   read_total;

  logic           clearing;
  logic [TAW-1:0] clr_cnt;

  // Input field views.
  logic       in_action;
  logic [1:0] in_sel;
  logic [7:0] in_char;
  logic [7:0] in_qual;
  logic [6:0] in_rpos;
  logic [5:0] in_ia;
  logic [5:0] in_ib;

  logic                  accept;
  logic                  advance;
  logic [QW-1:0]         q_clamp;
  rqpc_pkg::nt_code_t    code;
  logic [8:0]            bp9;
  logic [8:0]            rp9;
  logic                  in_range;
  logic [7:0]            len8;
  logic [NAW-1:0]        nuc_raddr;
  logic [QAW-1:0]        qual_raddr;
  logic [TAW-1:0]        tr_raddr;
  logic                  rd_bad;
  logic [31:0]           sum_val;

  // Stage 1 registers.
  logic           s1_valid;
  logic           s1_action;
  logic [1:0]     s1_sel;
  logic           s1_bad;
  logic [31:0]    s1_sum_val;
  logic [NAW-1:0] s1_nuc_addr;
  logic [QAW-1:0] s1_qual_addr;
  logic [TAW-1:0] s1_tr_addr;
  logic           s1_nuc_we;
  logic           s1_qual_we;
  logic           s1_tr_we;
  logic           nuc_fwd;
  logic           qual_fwd;
  logic           tr_fwd;

  logic [CW-1:0] nuc_rdata;
  logic [CW-1:0] qual_rdata;
  logic [CW-1:0] tr_rdata;
  logic [CW-1:0] nuc_fdata;
  logic [CW-1:0] qual_fdata;
  logic [CW-1:0] tr_fdata;
  logic [CW-1:0] nuc_eff;
  logic [CW-1:0] qual_eff;
  logic [CW-1:0] tr_eff;
  logic [CW-1:0] nuc_inc;
  logic [CW-1:0] qual_inc;
  logic [CW-1:0] tr_inc;

  logic           nuc_we;
  logic           qual_we;
  logic           tr_we;
  logic [NAW-1:0] nuc_waddr;
  logic [QAW-1:0] qual_waddr;
  logic [TAW-1:0] tr_waddr;
  logic [CW-1:0]  nuc_wdata;
  logic [CW-1:0]  qual_wdata;
  logic [CW-1:0]  tr_wdata;
  logic           s1_add_wr;
  logic [CW-1:0]  tbl_val;
  logic [63:0]    tbl_ext;
  logic [31:0]    out_val;

  assign in_action = s_axis_tuser[0];
  assign in_sel    = s_axis_tuser[2:1];
  assign in_char   = s_axis_tdata[7:0];
  assign in_qual   = s_axis_tdata[15:8];
  assign in_rpos   = s_axis_tdata[22:16];
  assign in_ia     = s_axis_tdata[28:23];
  assign in_ib     = s_axis_tdata[34:29];

  assign advance = !(s1_valid && (s1_action == rqpc_pkg::ACT_READ) &&
                     m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = !clearing && advance;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_clamp  = (in_qual > 8'(MAX_QUALITY)) ? QW'(MAX_QUALITY) : in_qual[QW-1:0];
    code     = rqpc_pkg::nt_code(in_char);
    bp9      = {1'b0, base_position};
    rp9      = {2'b00, in_rpos};
    in_range = bp9 < 9'(MAX_READ_LEN);
    len8     = (base_position == 8'd255) ? 8'd255 : base_position + 8'd1;
    if (in_action == rqpc_pkg::ACT_ADD) begin
      nuc_raddr  = {bp9[PW-1:0], code};
      qual_raddr = {bp9[PW-1:0], q_clamp};
      tr_raddr   = {bp9[PW-1:0], previous_quality, q_clamp};
    end else begin
      nuc_raddr  = {rp9[PW-1:0], in_ia[2:0]};
      qual_raddr = {rp9[PW-1:0], in_ia[QW-1:0]};
      tr_raddr   = {rp9[PW-1:0], in_ia[QW-1:0], in_ib[QW-1:0]};
    end
    case (in_ia)
      rqpc_pkg::SUM_MINLEN: sum_val = 32'(min_len);
      rqpc_pkg::SUM_MAXLEN: sum_val = 32'(max_len);
      rqpc_pkg::SUM_MAXQ:   sum_val = 32'(max_quality);
      rqpc_pkg::SUM_READS:  sum_val = read_total;
      default:              sum_val = 32'd0;
    endcase
    case (in_sel)
      rqpc_pkg::TBL_SUM:  rd_bad = in_ia > rqpc_pkg::SUM_READS;
      rqpc_pkg::TBL_NUC:  rd_bad = (rp9 >= 9'(MAX_READ_LEN)) ||
                                   (in_ia > 6'(rqpc_pkg::NT_N));
      rqpc_pkg::TBL_QUAL: rd_bad = (rp9 >= 9'(MAX_READ_LEN)) ||
                                   (in_ia > 6'(MAX_QUALITY));
      default:            rd_bad = (rp9 >= 9'(MAX_READ_LEN)) ||
                                   (in_ia > 6'(MAX_QUALITY)) ||
                                   (in_ib > 6'(MAX_QUALITY));
    endcase
  end

  // Read data of the previous write is forwarded when the next request
  // reads the entry being written on the same edge.
  always_comb begin
    nuc_eff  = nuc_fwd  ? nuc_fdata  : nuc_rdata;
    qual_eff = qual_fwd ? qual_fdata : qual_rdata;
    tr_eff   = tr_fwd   ? tr_fdata   : tr_rdata;
    nuc_inc  = (nuc_eff  == {CW{1'b1}}) ? nuc_eff  : nuc_eff  + CW'(1);
    qual_inc = (qual_eff == {CW{1'b1}}) ? qual_eff : qual_eff + CW'(1);
    tr_inc   = (tr_eff   == {CW{1'b1}}) ? tr_eff   : tr_eff   + CW'(1);
    s1_add_wr = s1_valid && (s1_action == rqpc_pkg::ACT_ADD);
    nuc_we   = clearing || (s1_add_wr && s1_nuc_we);
    qual_we  = clearing || (s1_add_wr && s1_qual_we);
    tr_we    = clearing || (s1_add_wr && s1_tr_we);
    nuc_waddr  = clearing ? clr_cnt[NAW-1:0] : s1_nuc_addr;
    qual_waddr = clearing ? clr_cnt[QAW-1:0] : s1_qual_addr;
    tr_waddr   = clearing ? clr_cnt          : s1_tr_addr;
    nuc_wdata  = clearing ? '0 : nuc_inc;
    qual_wdata = clearing ? '0 : qual_inc;
    tr_wdata   = clearing ? '0 : tr_inc;
    case (s1_sel)
      rqpc_pkg::TBL_NUC:  tbl_val = nuc_eff;
      rqpc_pkg::TBL_QUAL: tbl_val = qual_eff;
      default:            tbl_val = tr_eff;
    endcase
    tbl_ext = 64'(tbl_val);
    if (s1_bad) begin
      out_val = 32'd0;
    end else if (s1_sel == rqpc_pkg::TBL_SUM) begin
      out_val = s1_sum_val;
    end else if (tbl_ext > 64'h0000_0000_FFFF_FFFF) begin
      out_val = 32'hFFFF_FFFF;
    end else begin
      out_val = tbl_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (nuc_we) begin
      nuc_mem[nuc_waddr] <= nuc_wdata;
    end
    if (accept) begin
      nuc_rdata <= nuc_mem[nuc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (qual_we) begin
      qual_mem[qual_waddr] <= qual_wdata;
    end
    if (accept) begin
      qual_rdata <= qual_mem[qual_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tr_we) begin
      tr_mem[tr_waddr] <= tr_wdata;
    end
    if (accept) begin
      tr_rdata <= tr_mem[tr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nuc_fdata    <= nuc_inc;
      qual_fdata   <= qual_inc;
      tr_fdata     <= tr_inc;
      s1_action    <= in_action;
      s1_sel       <= in_sel;
      s1_bad       <= rd_bad;
      s1_sum_val   <= sum_val;
      s1_nuc_addr  <= nuc_raddr;
      s1_qual_addr <= qual_raddr;
      s1_tr_addr   <= tr_raddr;
      s1_nuc_we    <= in_range;
      s1_qual_we   <= in_range;
      s1_tr_we     <= in_range && (base_position != 8'd0);
      nuc_fwd      <= nuc_we && (nuc_waddr == nuc_raddr);
      qual_fwd     <= qual_we && (qual_waddr == qual_raddr);
      tr_fwd       <= tr_we && (tr_waddr == tr_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing         <= 1'b1;
      clr_cnt          <= '0;
      s1_valid         <= 1'b0;
      m_axis_tvalid    <= 1'b0;
      base_position    <= 8'd0;
      previous_quality <= '0;
      min_len          <= rqpc_pkg::LEN_NONE;
      max_len          <= 8'd0;
      max_quality      <= '0;
      read_total       <= 32'd0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + TAW'(1);
        if (clr_cnt == {TAW{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid <= accept;
      end
      if (s1_valid && (s1_action == rqpc_pkg::ACT_READ) && advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept && (in_action == rqpc_pkg::ACT_ADD)) begin
        if (q_clamp > max_quality) begin
          max_quality <= q_clamp;
        end
        if (s_axis_tlast) begin
          if (len8 < min_len) begin
            min_len <= len8;
          end
          if (len8 > max_len) begin
            max_len <= len8;
          end
          if (read_total != 32'hFFFF_FFFF) begin
            read_total <= read_total + 32'd1;
          end
          base_position    <= 8'd0;
          previous_quality <= '0;
        end else begin
          previous_quality <= q_clamp;
          if (base_position != 8'd255) begin
            base_position <= base_position + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && (s1_action == rqpc_pkg::ACT_READ) && advance) begin
      m_axis_tdata <= out_val;
      m_axis_tuser <= s1_bad;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("request accepted during the clearing pass");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("bad readout index with nonzero value");

  a_readout_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_action == rqpc_pkg::ACT_READ) && advance) |=> m_axis_tvalid)
    else $error("readout result lost before the output register");

  a_no_reads_no_lengths: assert property (@(posedge clk) disable iff (rst)
    (read_total == 32'd0) |-> ((max_len == 8'd0) && (min_len == rqpc_pkg::LEN_NONE)))
    else $error("read lengths recorded without a completed read");

  a_stage_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("counter update in flight during the clearing pass");

endmodule

/* dv/tb_read_quality_profile_counter_core.sv */
// ----------------------------------------------------------------------------
// Read quality profile counter testbench
// Streams reads and readout requests into the core with random gaps and
// output stalls, and checks every readout result against fixed expected
// values or a predictor of the per-position counters and read summaries kept here.
// ----------------------------------------------------------------------------
module tb_read_quality_profile_counter_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int READ_CAP   = 128;
  localparam int QUAL_TOP   = 63;
  localparam int QUAL_LVLS  = QUAL_TOP + 1;
  localparam int BASE_ITEMS = 1950;
  localparam int LONG_READ  = 290;

  typedef struct packed {
    logic       act;
    logic [7:0] ch;
    logic [7:0] qual;
    logic       last;
    logic [1:0] tbl;
    logic [6:0] pos;
    logic [5:0] ia;
    logic [5:0] ib;
  } request_t;

  typedef struct packed {
    logic [31:0] value;
    logic        bad;
  } count_result_t;

  typedef struct {
    request_t      req;
    bit            typed;
    count_result_t want;
  } vector_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  bit [31:0] nuc_tally[int];
  bit [31:0] qual_tally[int];
  bit [31:0] trans_tally[int];
  bit [7:0]  cur_pos;
  bit [5:0]  prev_qual;
  bit [7:0]  shortest_len;
  bit [7:0]  longest_len;
  bit [5:0]  top_qual;
  bit [31:0] reads_done;

  count_result_t pending_counts[$];
  vector_row_t   vectors[$];
  int            errors;
  int            sent_items;
  bit            send_calm;
  bit            drain_calm;

  read_quality_profile_counter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic rqpc_pkg::nt_code_t base_code(input logic [7:0] c);
    case (c)
      "A", "a": return rqpc_pkg::NT_A;
      "C", "c": return rqpc_pkg::NT_C;
      "G", "g": return rqpc_pkg::NT_G;
      "T", "t": return rqpc_pkg::NT_T;
      default:  return rqpc_pkg::NT_N;
    endcase
  endfunction

  function automatic bit [31:0] sat_inc(input bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Updates the profile with one request; returns 1 with the readout value
  // when the request is a readout.
  function automatic bit profile_step(input request_t r, output count_result_t res);
    bit [5:0] q;
    int       k;
    int       len;
    res = '0;
    if (r.act == rqpc_pkg::ACT_ADD) begin
      q = (r.qual > QUAL_TOP) ? 6'(QUAL_TOP) : r.qual[5:0];
      if (q > top_qual) begin
        top_qual = q;
      end
      if (cur_pos < READ_CAP) begin
        k = cur_pos * 5 + base_code(r.ch);
        nuc_tally[k] = sat_inc(nuc_tally.exists(k) ? nuc_tally[k] : 32'd0);
        k = cur_pos * QUAL_LVLS + q;
        qual_tally[k] = sat_inc(qual_tally.exists(k) ? qual_tally[k] : 32'd0);
        if (cur_pos > 0) begin
          k = (cur_pos * QUAL_LVLS + prev_qual) * QUAL_LVLS + q;
          trans_tally[k] = sat_inc(trans_tally.exists(k) ? trans_tally[k] : 32'd0);
        end
      end
      prev_qual = q;
      if (r.last) begin
        len = cur_pos + 1;
        if (len > 255) begin
          len = 255;
        end
        if (len < shortest_len) begin
          shortest_len = 8'(len);
        end
        if (len > longest_len) begin
          longest_len = 8'(len);
        end
        reads_done = sat_inc(reads_done);
        cur_pos = 0;
        prev_qual = 0;
      end else if (cur_pos < 255) begin
        cur_pos++;
      end
      return 1'b0;
    end
    if (r.tbl == rqpc_pkg::TBL_SUM) begin
      case (r.ia)
        rqpc_pkg::SUM_MINLEN: res.value = 32'(shortest_len);
        rqpc_pkg::SUM_MAXLEN: res.value = 32'(longest_len);
        rqpc_pkg::SUM_MAXQ:   res.value = 32'(top_qual);
        rqpc_pkg::SUM_READS:  res.value = reads_done;
        default:              res.bad = 1'b1;
      endcase
    end else if (r.pos >= READ_CAP) begin
      res.bad = 1'b1;
    end else if (r.tbl == rqpc_pkg::TBL_NUC) begin
      k = r.pos * 5 + r.ia;
      if (r.ia > rqpc_pkg::NT_N) begin
        res.bad = 1'b1;
      end else if (nuc_tally.exists(k)) begin
        res.value = nuc_tally[k];
      end
    end else if (r.tbl == rqpc_pkg::TBL_QUAL) begin
      k = r.pos * QUAL_LVLS + r.ia;
      if (r.ia > QUAL_TOP) begin
        res.bad = 1'b1;
      end else if (qual_tally.exists(k)) begin
        res.value = qual_tally[k];
      end
    end else begin
      k = (r.pos * QUAL_LVLS + r.ia) * QUAL_LVLS + r.ib;
      if (r.ia > QUAL_TOP || r.ib > QUAL_TOP) begin
        res.bad = 1'b1;
      end else if (trans_tally.exists(k)) begin
        res.value = trans_tally[k];
      end
    end
    if (res.bad) begin
      res.value = '0;
    end
    return 1'b1;
  endfunction

  function automatic request_t base_req(input logic [7:0] ch, input logic [7:0] q,
                                        input logic last);
    request_t r;
    r.act  = rqpc_pkg::ACT_ADD;
    r.ch   = ch;
    r.qual = q;
    r.last = last;
    r.tbl  = 2'($urandom_range(0, 3));
    r.pos  = 7'($urandom_range(0, 127));
    r.ia   = 6'($urandom_range(0, 63));
    r.ib   = 6'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic request_t read_req(input logic [1:0] tbl, input logic [6:0] pos,
                                        input logic [5:0] ia, input logic [5:0] ib);
    request_t r;
    r.act  = rqpc_pkg::ACT_READ;
    r.ch   = 8'($urandom_range(0, 255));
    r.qual = 8'($urandom_range(0, 255));
    r.last = 1'($urandom_range(0, 1));
    r.tbl  = tbl;
    r.pos  = pos;
    r.ia   = ia;
    r.ib   = ib;
    return r;
  endfunction

  function automatic void add_row(input request_t r, input bit typed,
                                  input logic [31:0] v, input logic b);
    vector_row_t row;
    row.req        = r;
    row.typed      = typed;
    row.want.value = v;
    row.want.bad   = b;
    vectors.push_back(row);
  endfunction

  // Most qualities come from a narrow band so that transitions repeat.
  function automatic logic [7:0] pick_quality();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 8'($urandom_range(30, 33));
    end else if (roll < 85) begin
      return 8'($urandom_range(0, 63));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_base();
    string letters;
    letters = "ACGTacgtN";
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return letters[$urandom_range(0, 8)];
  endfunction

  function automatic request_t random_readout();
    logic [1:0] tbl;
    logic [6:0] pos;
    logic [5:0] ia;
    logic [5:0] ib;
    tbl = 2'($urandom_range(0, 3));
    pos = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 15)) : 7'($urandom_range(0, 127));
    ib  = 6'($urandom_range(0, 63));
    case (tbl)
      rqpc_pkg::TBL_NUC: ia = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 4))
                                                           : 6'($urandom_range(0, 63));
      rqpc_pkg::TBL_SUM: ia = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 3))
                                                           : 6'($urandom_range(0, 63));
      default: begin
        ia = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(30, 33)) : 6'($urandom_range(0, 63));
        ib = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(30, 33)) : ib;
      end
    endcase
    return read_req(tbl, pos, ia, ib);
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_request(input request_t r, input bit typed, input count_result_t want);
    int            gap;
    bit            has_result;
    count_result_t predicted;
    if ($urandom_range(0, 63) == 0) begin
      send_calm = !send_calm;
    end
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, r.ib, r.ia, r.pos, r.qual, r.ch};
    s_axis_tuser  <= {r.tbl, r.act};
    s_axis_tlast  <= r.last;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    has_result = profile_step(r, predicted);
    if (has_result) begin
      pending_counts.push_back(typed ? want : predicted);
    end
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_read(input int len);
    for (int i = 0; i < len; i++) begin
      send_request(base_req(pick_base(), pick_quality(), i == len - 1), 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  initial begin
    count_result_t got;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      int gap;
      if ($urandom_range(0, 63) == 0) begin
        drain_calm = !drain_calm;
      end
      gap = drain_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) begin
        @(posedge clk);
      end
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result count_value=%h bad_index=%b",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        got = pending_counts.pop_front();
        if (m_axis_tdata !== got.value) begin
          $display("%0t: count_value expected %h actual %h", $time, got.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== got.bad) begin
          $display("%0t: bad_index expected %b actual %b", $time, got.bad, m_axis_tuser);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit paused;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cur_pos       = '0;
    prev_qual     = '0;
    shortest_len  = rqpc_pkg::LEN_NONE;
    longest_len   = '0;
    top_qual      = '0;
    reads_done    = '0;
    errors        = 0;
    sent_items    = 0;
    paused        = 1'b0;

    // Empty profile, then bad and highest valid indexes, then a short read and a one-base read.
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MINLEN, 6'd0),
            1'b1, 32'd255, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MAXLEN, 6'd0),
            1'b1, 32'd0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MAXQ, 6'd0),
            1'b1, 32'd0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_READS, 6'd0),
            1'b1, 32'd0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd127, 6'd63, 6'd63), 1'b1, 32'd0, 1'b1);
    add_row(read_req(rqpc_pkg::TBL_NUC, 7'd0, 6'd5, 6'd0), 1'b1, 32'd0, 1'b1);
    add_row(read_req(rqpc_pkg::TBL_NUC, 7'd127, 6'd63, 6'd0), 1'b1, 32'd0, 1'b1);
    add_row(read_req(rqpc_pkg::TBL_QUAL, 7'd127, 6'd63, 6'd0), 1'b1, 32'd0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_TR, 7'd127, 6'd63, 6'd63), 1'b1, 32'd0, 1'b0);
    add_row(base_req("a", 8'd255, 1'b0), 1'b0, '0, 1'b0);
    add_row(base_req("G", 8'd0, 1'b0), 1'b0, '0, 1'b0);
    add_row(base_req("t", 8'd40, 1'b1), 1'b0, '0, 1'b0);
    add_row(base_req(8'hFF, 8'd63, 1'b1), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_NUC, 7'd0, 6'(rqpc_pkg::NT_A), 6'd0), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_NUC, 7'd0, 6'(rqpc_pkg::NT_N), 6'd0), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_QUAL, 7'd0, 6'd63, 6'd0), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_TR, 7'd0, 6'd0, 6'd63), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_TR, 7'd1, 6'd63, 6'd0), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_TR, 7'd2, 6'd0, 6'd40), 1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MINLEN, 6'd0),
            1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MAXLEN, 6'd0),
            1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MAXQ, 6'd0),
            1'b0, '0, 1'b0);
    add_row(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_READS, 6'd0),
            1'b0, '0, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) begin
      send_request(vectors[i].req, vectors[i].typed, vectors[i].want);
    end

    while (sent_items < BASE_ITEMS) begin
      if (!paused && sent_items >= BASE_ITEMS / 2) begin
        // A read longer than the tables and than the length counter.
        wait_drained();
        send_read(LONG_READ);
        send_request(read_req(rqpc_pkg::TBL_SUM, 7'd0, rqpc_pkg::SUM_MAXLEN, 6'd0),
                     1'b0, '0);
        send_request(read_req(rqpc_pkg::TBL_QUAL, 7'd127, 6'($urandom_range(30, 33)),
                              6'd0), 1'b0, '0);
        paused = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin
        send_read(($urandom_range(0, 29) == 0) ? $urandom_range(17, 140) : $urandom_range(1, 16));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_request(random_readout(), 1'b0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
